FILE: hdl/swv_pkg.sv
// ----------------------------------------------------------------------------
// swv_pkg
// Shared types, constants and the arctangent table for the swerve drive
// inverse kinematics block.
// ----------------------------------------------------------------------------
`default_nettype none

package swv_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_ERPM_SCALE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE  = 1'b1;

  localparam int SCALE_W = 24;
  localparam int DZ_W    = 10;
  localparam logic [SCALE_W-1:0] ERPM_SCALE_RST = 24'd65536;
  localparam logic [DZ_W-1:0]    DEAD_ZONE_RST  = 10'd3;

  // Result fields
  localparam int SPEED_W = 24;
  localparam int ANGLE_W = 16;
  localparam logic [1:0] WHEEL_LAST = 2'd3;

  // Fixed point
  localparam int FRAC_BITS = 8;
  localparam int ZW        = 32;
  localparam logic signed [15:0] HALF_SQRT2_Q15 = 16'sd23170;
  localparam logic signed [15:0] ROT_ROUND      = 16'sd16384;
  localparam logic [23:0]        CORDIC_GAIN_Q24 = 24'd10188014;
  localparam logic signed [ZW-1:0] Z_HALF = 32'sd32768;
  localparam logic signed [ZW-1:0] Z_A90  = 32'sd9000;
  localparam logic [23:0] SPEED_ROUND = 24'h800000;

  // Angles in centidegrees
  localparam logic [ANGLE_W-1:0] ANG_90  = 16'd9000;
  localparam logic [ANGLE_W-1:0] ANG_180 = 16'd18000;
  localparam logic [ANGLE_W-1:0] ANG_270 = 16'd27000;
  localparam logic [ANGLE_W-1:0] ANG_360 = 16'd36000;

  typedef enum logic [1:0] {
    DZ_NONE,
    DZ_ZERO,
    DZ_90,
    DZ_270
  } dz_mode_t;

  // Control that travels alongside each wheel through the pipeline.
  typedef struct packed {
    logic       valid;
    logic [1:0] wheel;
    logic       last;
    logic       xneg;
    logic       yneg;
    logic       zero;
    dz_mode_t   dz;
  } side_t;

  // atan(2^-i) in centidegrees with 16 fraction bits.
  function automatic logic [29:0] swv_atan(input int idx);
    logic [29:0] v;
    case (idx)
      0:       v = 30'd294912000;
      1:       v = 30'd174096719;
      2:       v = 30'd91987925;
      3:       v = 30'd46694507;
      4:       v = 30'd23437866;
      5:       v = 30'd11730358;
      6:       v = 30'd5866610;
      7:       v = 30'd2933484;
      8:       v = 30'd1466764;
      9:       v = 30'd733385;
      10:      v = 30'd366693;
      11:      v = 30'd183346;
      12:      v = 30'd91673;
      13:      v = 30'd45837;
      14:      v = 30'd22918;
      15:      v = 30'd11459;
      16:      v = 30'd5730;
      17:      v = 30'd2865;
      18:      v = 30'd1432;
      19:      v = 30'd716;
      20:      v = 30'd358;
      21:      v = 30'd179;
      22:      v = 30'd90;
      23:      v = 30'd45;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/swv_ifs.sv
// ----------------------------------------------------------------------------
// swv_ifs
// Valid/ready channels for chassis commands and per-wheel results.
// ----------------------------------------------------------------------------
`default_nettype none

interface swv_cmd_if #(parameter int VEL_WIDTH = 16);
  logic                        valid;
  logic                        ready;
  logic signed [VEL_WIDTH-1:0] vel_x;
  logic signed [VEL_WIDTH-1:0] vel_y;
  logic signed [VEL_WIDTH-1:0] vel_rot;

  modport source (output valid, output vel_x, output vel_y, output vel_rot,
                  input ready);
  modport sink (input valid, input vel_x, input vel_y, input vel_rot,
                output ready);
endinterface

interface swv_whl_if;
  logic        valid;
  logic        ready;
  logic [1:0]  wheel_index;
  logic [23:0] speed_erpm;
  logic [15:0] angle_centideg;
  logic        last;

  modport source (output valid, output wheel_index, output speed_erpm,
                  output angle_centideg, output last, input ready);
  modport sink (input valid, input wheel_index, input speed_erpm,
                input angle_centideg, input last, output ready);
endinterface

`default_nettype wire

FILE: hdl/swv_front.sv
// ----------------------------------------------------------------------------
// swv_front
// Command register, rotation term and wheel sequencer. Emits one wheel vector
// per cycle while adv is high, in absolute fixed point, into the CORDIC chain.
// ----------------------------------------------------------------------------
`default_nettype none

module swv_front import swv_pkg::*; #(
  parameter int VEL_WIDTH = 16,
  parameter int CW        = 27
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic [DZ_W-1:0]             dead_zone,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [VEL_WIDTH-1:0] vel_x,
  input  logic signed [VEL_WIDTH-1:0] vel_y,
  input  logic signed [VEL_WIDTH-1:0] vel_rot,
  output side_t                       side_o,
  output logic signed [CW-1:0]        x_o,
  output logic signed [CW-1:0]        y_o
);

  localparam int RW   = VEL_WIDTH + 1;
  localparam int PW   = VEL_WIDTH + 16;
  localparam int SW   = VEL_WIDTH + 2;
  localparam int AW   = VEL_WIDTH;
  localparam int CMPW = ((SW > DZ_W + 1) ? SW : DZ_W + 1) + 1;

  logic signed [VEL_WIDTH-1:0] vx;
  logic signed [VEL_WIDTH-1:0] vy;
  logic signed [RW-1:0]        r;
  logic                        busy;
  logic [1:0]                  k;

  logic signed [PW-1:0]   rprod;
  logic signed [SW-1:0]   wx;
  logic signed [SW-1:0]   wy;
  logic signed [SW-1:0]   rx;
  logic signed [SW-1:0]   ry;
  logic [SW-1:0]          ax_full;
  logic [SW-1:0]          ay_full;
  logic [AW-1:0]          ax;
  logic [AW-1:0]          ay;
  logic signed [CMPW-1:0] axc;
  logic signed [CMPW-1:0] wyc;
  logic signed [CMPW-1:0] dzc;
  logic                   in_xfer;
  side_t                  side_next;

  assign in_ready = adv && (!busy || k == WHEEL_LAST);
  assign in_xfer  = in_valid && in_ready;

  // Rounded rotation term, vel_rot * 0.7071 with halves going up.
  assign rprod = PW'(vel_rot) * PW'(HALF_SQRT2_Q15) + PW'(ROT_ROUND);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      k    <= 2'd0;
    end else if (adv) begin
      if (busy) begin
        k <= k + 2'd1;
      end
      if (in_xfer) begin
        busy <= 1'b1;
        k    <= 2'd0;
      end else if (busy && k == WHEEL_LAST) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      vx <= vel_x;
      vy <= vel_y;
      r  <= rprod[PW-1:15];
    end
  end

  // Wheels 0 and 1 subtract r from x; wheels 0 and 3 add r to y.
  always_comb begin
    rx      = k[1] ? SW'(r) : -SW'(r);
    ry      = (k[1] == k[0]) ? SW'(r) : -SW'(r);
    wx      = SW'(vx) + rx;
    wy      = SW'(vy) + ry;
    ax_full = wx[SW-1] ? unsigned'(-wx) : unsigned'(wx);
    ay_full = wy[SW-1] ? unsigned'(-wy) : unsigned'(wy);
    ax      = ax_full[AW-1:0];
    ay      = ay_full[AW-1:0];
    axc     = signed'(CMPW'(ax));
    wyc     = CMPW'(wy);
    dzc     = signed'(CMPW'(dead_zone));

    side_next.valid = busy;
    side_next.wheel = k;
    side_next.last  = (k == WHEEL_LAST);
    side_next.xneg  = wx[SW-1];
    side_next.yneg  = wy[SW-1];
    side_next.zero  = (wx == '0) && (wy == '0);
    if (axc < dzc) begin
      if (wyc < -dzc) begin
        side_next.dz = DZ_270;
      end else if (wyc > dzc) begin
        side_next.dz = DZ_90;
      end else begin
        side_next.dz = DZ_ZERO;
      end
    end else begin
      side_next.dz = DZ_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_o <= '0;
    end else if (adv) begin
      side_o <= side_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_o <= signed'(CW'({ax, {FRAC_BITS{1'b0}}}));
      y_o <= signed'(CW'({ay, {FRAC_BITS{1'b0}}}));
    end
  end

endmodule

`default_nettype wire

FILE: hdl/swv_cordic_cell.sv
// ----------------------------------------------------------------------------
// swv_cordic_cell
// One vectoring CORDIC micro-rotation with a fixed shift, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module swv_cordic_cell import swv_pkg::*; #(
  parameter int IDX = 0,
  parameter int CW  = 27
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  side_t                side_i,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  output side_t                side_o,
  output logic signed [CW-1:0] x_o,
  output logic signed [CW-1:0] y_o,
  output logic signed [ZW-1:0] z_o
);

  localparam logic signed [ZW-1:0] ANG = signed'(ZW'(swv_atan(IDX)));

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;

  assign dx = y_i >>> IDX;
  assign dy = x_i >>> IDX;

  always_ff @(posedge clk) begin
    if (rst) begin
      side_o <= '0;
    end else if (en) begin
      side_o <= side_i;
    end
  end

  // Rotate toward the x axis, steering by the sign of y.
  always_ff @(posedge clk) begin
    if (en) begin
      if (!y_i[CW-1]) begin
        x_o <= x_i + dx;
        y_o <= y_i - dy;
        z_o <= z_i + ANG;
      end else begin
        x_o <= x_i - dx;
        y_o <= y_i + dy;
        z_o <= z_i - ANG;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/swv_post.sv
// ----------------------------------------------------------------------------
// swv_post
// Gain correction, ERPM scaling with saturation, quadrant mapping and
// dead zone override, ending in the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module swv_post import swv_pkg::*; #(
  parameter int CW = 27
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic [SCALE_W-1:0]   erpm_scale,
  input  side_t                side_i,
  input  logic signed [CW-1:0] cx,
  input  logic signed [ZW-1:0] z,
  output logic                 out_valid,
  output logic [1:0]           out_wheel,
  output logic [SPEED_W-1:0]   out_speed,
  output logic [ANGLE_W-1:0]   out_angle,
  output logic                 out_last
);

  localparam int CXW = CW - 1;
  localparam int LO  = (CXW + 1) / 2;
  localparam int HI  = CXW - LO;
  localparam int PLW = LO + 24;
  localparam int PHW = HI + 24;
  localparam int GW  = CXW + 24;
  localparam int QW  = (CXW + 1 > SPEED_W + 1) ? CXW + 1 : SPEED_W + 1;
  localparam int EW  = QW + 24;

  // Stage 1: gain partial products, first-quadrant angle
  side_t                 s1;
  logic [PLW-1:0]        pg_lo;
  logic [PHW-1:0]        pg_hi;
  logic [13:0]           a1;
  // Stage 2: magnitude, full angle
  side_t                 s2;
  logic [CXW-1:0]        mag;
  logic [ANGLE_W-1:0]    ang2;
  // Stage 3: ERPM partial products
  side_t                 s3;
  logic [PLW-1:0]        pe_lo;
  logic [PHW-1:0]        pe_hi;
  logic [ANGLE_W-1:0]    ang3;

  logic [CXW-1:0]        cxc;
  logic signed [ZW-1:0]  zs;
  logic [13:0]           a1_next;
  logic [GW-1:0]         gsum;
  logic [ANGLE_W-1:0]    a16;
  logic [ANGLE_W-1:0]    am;
  logic [ANGLE_W-1:0]    ang2_next;
  logic [EW-1:0]         esum;
  logic [QW-1:0]         q;
  logic [SPEED_W-1:0]    speed_next;

  always_comb begin
    cxc = cx[CW-1] ? '0 : cx[CXW-1:0];
    zs  = (z + Z_HALF) >>> 16;
    if (zs < 0) begin
      a1_next = '0;
    end else if (zs > Z_A90) begin
      a1_next = 14'(Z_A90);
    end else begin
      a1_next = zs[13:0];
    end
  end

  always_comb begin
    gsum = (GW'(pg_hi) << LO) + GW'(pg_lo);
    a16  = ANGLE_W'(a1);
    case ({s1.xneg, s1.yneg})
      2'b00:   am = a16;
      2'b10:   am = ANG_180 - a16;
      2'b11:   am = ANG_180 + a16;
      default: am = ANG_360 - a16;
    endcase
    if (am == ANG_360 || s1.zero) begin
      am = '0;
    end
    unique case (s1.dz)
      DZ_NONE: ang2_next = am;
      DZ_ZERO: ang2_next = '0;
      DZ_90:   ang2_next = ANG_90;
      DZ_270:  ang2_next = ANG_270;
    endcase
  end

  always_comb begin
    esum = (EW'(pe_hi) << LO) + EW'(pe_lo) + EW'(SPEED_ROUND);
    q    = esum[EW-1:24];
    if (s3.zero) begin
      speed_next = '0;
    end else if (|q[QW-1:SPEED_W]) begin
      speed_next = '1;
    end else begin
      speed_next = q[SPEED_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1        <= '0;
      s2        <= '0;
      s3        <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1        <= side_i;
      s2        <= s1;
      s3        <= s2;
      out_valid <= s3.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pg_lo     <= PLW'(cxc[LO-1:0]) * PLW'(CORDIC_GAIN_Q24);
      pg_hi     <= PHW'(cxc[CXW-1:LO]) * PHW'(CORDIC_GAIN_Q24);
      a1        <= a1_next;
      mag       <= gsum[GW-1:24];
      ang2      <= ang2_next;
      pe_lo     <= PLW'(mag[LO-1:0]) * PLW'(erpm_scale);
      pe_hi     <= PHW'(mag[CXW-1:LO]) * PHW'(erpm_scale);
      ang3      <= ang2;
      out_wheel <= s3.wheel;
      out_last  <= s3.last;
      out_speed <= speed_next;
      out_angle <= ang3;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/swerve_four_wheel_kinematics.sv
// A command transfer passes through the command register, the front register,
// the CORDIC cells and the post stages to its first result; the wheel sequencer
// feeds one wheel vector a cycle while the result register is free, giving one
// wheel result per cycle, and takes a new command as it sends the fourth wheel.
// Reset clears the pipeline valid bits and loads erpm_scale = 1.0, dead_zone = 3.
// ----------------------------------------------------------------------------
// swerve_four_wheel_kinematics
// Four-wheel swerve inverse kinematics: wheel vectors, vectoring CORDIC
// chain, ERPM scaling and steering angle per wheel.
// ----------------------------------------------------------------------------
`default_nettype none

module swerve_four_wheel_kinematics import swv_pkg::*; #(
  parameter int CORDIC_STAGES = 16,
  parameter int VEL_WIDTH     = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  swv_cmd_if.sink               cmd,
  swv_whl_if.source             whl
);

  localparam int CW = VEL_WIDTH + 11;

  logic [SCALE_W-1:0] erpm_scale;
  logic [DZ_W-1:0]    dead_zone;
  logic               adv;

  side_t                sd [0:CORDIC_STAGES];
  logic signed [CW-1:0] cx [0:CORDIC_STAGES];
  logic signed [CW-1:0] cy [0:CORDIC_STAGES];
  logic signed [ZW-1:0] cz [0:CORDIC_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      erpm_scale <= ERPM_SCALE_RST;
      dead_zone  <= DEAD_ZONE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ERPM_SCALE: erpm_scale <= cfg_data[SCALE_W-1:0];
        REG_DEAD_ZONE:  dead_zone  <= cfg_data[DZ_W-1:0];
      endcase
    end
  end

  // The whole pipeline moves whenever the result register is free.
  assign adv   = !whl.valid || whl.ready;
  assign cz[0] = '0;

  swv_front #(
    .VEL_WIDTH (VEL_WIDTH),
    .CW        (CW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .dead_zone (dead_zone),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .vel_x     (cmd.vel_x),
    .vel_y     (cmd.vel_y),
    .vel_rot   (cmd.vel_rot),
    .side_o    (sd[0]),
    .x_o       (cx[0]),
    .y_o       (cy[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    swv_cordic_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (adv),
      .side_i (sd[i]),
      .x_i    (cx[i]),
      .y_i    (cy[i]),
      .z_i    (cz[i]),
      .side_o (sd[i+1]),
      .x_o    (cx[i+1]),
      .y_o    (cy[i+1]),
      .z_o    (cz[i+1])
    );
  end

  swv_post #(
    .CW (CW)
  ) u_post (
    .clk        (clk),
    .rst        (rst),
    .en         (adv),
    .erpm_scale (erpm_scale),
    .side_i     (sd[CORDIC_STAGES]),
    .cx         (cx[CORDIC_STAGES]),
    .z          (cz[CORDIC_STAGES]),
    .out_valid  (whl.valid),
    .out_wheel  (whl.wheel_index),
    .out_speed  (whl.speed_erpm),
    .out_angle  (whl.angle_centideg),
    .out_last   (whl.last)
  );

  a_last_wheel : assert property (@(posedge clk) disable iff (rst)
    whl.valid && whl.last |-> whl.wheel_index == WHEEL_LAST)
    else $error("last marker on a wheel other than the fourth");

  a_not_last_wheel : assert property (@(posedge clk) disable iff (rst)
    whl.valid && !whl.last |-> whl.wheel_index != WHEEL_LAST)
    else $error("fourth wheel without last marker");

  a_angle_range : assert property (@(posedge clk) disable iff (rst)
    whl.valid |-> whl.angle_centideg < ANG_360)
    else $error("steering angle out of range");

  a_accept_moves : assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready |-> !whl.valid || whl.ready)
    else $error("command transfer while the pipeline is stalled");

endmodule

`default_nettype wire
